// ----- hdl/tkf_pkg.sv -----
// Shared types and constants of the tilt Kalman filter.
// No dependencies; used by every module of the block.
package tkf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS      = 24;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 28;

  localparam logic [23:0] Q_ANGLE_RST   = 24'd16777;
  localparam logic [23:0] Q_BIAS_RST    = 24'd50331;
  localparam logic [27:0] R_MEASURE_RST = 28'd1677722;
  localparam logic [23:0] TIME_STEP_RST = 24'd33554;

  typedef enum logic [1:0] {
    REG_Q_ANGLE, REG_Q_BIAS, REG_R_MEASURE, REG_TIME_STEP
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] q_angle;
    logic [23:0] q_bias;
    logic [27:0] r_measure;
    logic [23:0] time_step;
  } cfg_t;

  // multiply steps, in issue order
  typedef enum logic [3:0] {
    MOP_ANG, MOP_D, MOP_AA, MOP_BB, MOP_A2, MOP_B2, MOP_P0, MOP_P1, MOP_P2, MOP_P3
  } mop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_YS, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_wb;
    logic ys;
    logic div_start;
    logic div_wb;
    logic div_sel;
    logic out_load;
    mop_t op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic s_pos;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/tkf_mul.sv -----
// Sequential signed fixed-point multiplier: four half-width partial products,
// then rounding (drop 24 fraction bits) and saturation. Uses tkf_pkg.
module tkf_mul #(
  parameter int W = tkf_pkg::DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [((W+2 > 32) ? W+2 : 32)-1:0] a,
  input  logic signed [((W+2 > 32) ? W+2 : 32)-1:0] b,
  output logic signed [W-1:0] p,
  output logic done
);
  import tkf_pkg::*;

  localparam int MW = (W+2 > 32) ? W+2 : 32;
  localparam int H  = (MW+1)/2;
  localparam int PW = 4*H;

  logic [2*H-1:0] ua_r, ub_r;
  logic           neg_r;
  logic [PW-1:0]  acc_r;
  logic [2:0]     cnt_r;
  logic           busy_r, done_r;
  logic signed [W-1:0] p_r;

  logic [MW-1:0]  mag_a, mag_b;
  logic [H-1:0]   pa, pb;
  logic [2*H-1:0] pp;
  logic [PW-1:0]  pp_sh;
  logic [PW:0]    rnd;
  logic [PW:0]    maxmag;
  logic [PW:0]    m;
  logic           ovf64;

  assign mag_a = a[MW-1] ? (~a + MW'(1)) : a;
  assign mag_b = b[MW-1] ? (~b + MW'(1)) : b;

  assign pa = cnt_r[0] ? ua_r[2*H-1:H] : ua_r[H-1:0];
  assign pb = cnt_r[1] ? ub_r[2*H-1:H] : ub_r[H-1:0];
  assign pp = pa * pb;

  always_comb begin
    case ({1'b0, cnt_r[0]} + {1'b0, cnt_r[1]})
      2'd0:    pp_sh = PW'(pp);
      2'd1:    pp_sh = PW'(pp) << H;
      default: pp_sh = PW'(pp) << (2*H);
    endcase
  end

  // products of 2^64 and above clamp regardless of width
  assign ovf64  = |(acc_r >> 64);
  assign rnd    = (PW+1)'(acc_r >> FRAC_BITS) + (PW+1)'(acc_r[FRAC_BITS-1]);
  assign maxmag = ((PW+1)'(1) << (W-1)) - (neg_r ? (PW+1)'(0) : (PW+1)'(1));
  assign m      = (ovf64 || (rnd > maxmag)) ? maxmag : rnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua_r  <= (2*H)'(mag_a);
      ub_r  <= (2*H)'(mag_b);
      neg_r <= a[MW-1] ^ b[MW-1];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == 3'd4) begin
        p_r <= neg_r ? W'(~m + (PW+1)'(1)) : W'(m);
      end else begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  assign p    = p_r;
  assign done = done_r;
endmodule

// ----- hdl/tkf_div.sv -----
// Restoring divider for the Kalman gains: num/den as signed Q8.24, one
// quotient bit a cycle, truncated toward zero, clamped at magnitude 128.
module tkf_div #(
  parameter int W = tkf_pkg::DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [W-1:0] num,
  input  logic [((W > 28) ? W : 28)+2-2:0] den,
  output logic signed [31:0] q,
  output logic done
);
  import tkf_pkg::*;

  localparam int SW = ((W > 28) ? W : 28) + 2;
  localparam int DN = SW - 1;
  localparam int CW = SW + 7;

  logic [DN-1:0] den_r, rem_r;
  logic [30:0]   nsh_r, qt_r;
  logic [4:0]    step_r;
  logic          busy_r, done_r, neg_r, ovf_r;

  logic [W-1:0]  un;
  logic [SW-1:0] trial;
  logic          ge;

  assign un    = num[W-1] ? (~num + W'(1)) : num;
  assign trial = {rem_r, nsh_r[30]};
  assign ge    = trial >= SW'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 5'd30;
      end else if (busy_r) begin
        if (step_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      neg_r <= num[W-1];
      ovf_r <= CW'(un) >= (CW'(den) << 7);
      rem_r <= DN'(un >> 7);
      nsh_r <= {un[6:0], 24'd0};
      qt_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DN'(trial - SW'(den_r)) : DN'(trial);
      nsh_r <= {nsh_r[29:0], 1'b0};
      qt_r  <= {qt_r[29:0], ge};
    end
  end

  always_comb begin
    if (ovf_r) q = neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else       q = neg_r ? -$signed({1'b0, qt_r}) : $signed({1'b0, qt_r});
  end

  assign done = done_r;
endmodule

// ----- hdl/tkf_datapath.sv -----
// Filter datapath: state, temporaries, output register, shared multiplier
// and divider. Driven by tkf_ctrl commands; uses tkf_pkg, tkf_mul, tkf_div.
module tkf_datapath #(
  parameter int W = tkf_pkg::DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  tkf_pkg::cfg_t cfg,
  input  tkf_pkg::cmd_t cmd,
  output tkf_pkg::sts_t sts,
  input  logic signed [31:0] in_accel_angle,
  input  logic signed [31:0] in_gyro_rate,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] out_filtered_angle,
  output logic signed [31:0] out_bias_estimate
);
  import tkf_pkg::*;

  localparam int MW = (W+2 > 32) ? W+2 : 32;
  localparam int XW = ((W > 32) ? W : 32) + 3;
  localparam int SW = ((W > 28) ? W : 28) + 2;
  localparam int IW = MW;
  localparam logic signed [XW-1:0] SMAX = (XW'(1) << (W-1)) - XW'(1);
  localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);

  function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] x);
    if (x > SMAX)      sat = W'(SMAX);
    else if (x < SMIN) sat = W'(SMIN);
    else               sat = W'(x);
  endfunction

  logic signed [31:0]   acc_r, k0_r, k1_r;
  logic signed [W-1:0]  rate_r, angle_r, bias_r, aa_r, ab_r, ba_r, bb_r;
  logic signed [W-1:0]  d_r, y_r, p00_r, p01_r;
  logic signed [IW-1:0] inner_r;
  logic signed [SW-1:0] s_r;
  logic                 out_valid_r;
  logic signed [31:0]   out_ang_r, out_bias_r;

  logic signed [MW-1:0] ma, mb, dt_m, qb_m;
  logic signed [W-1:0]  m;
  logic                 m_done;
  logic signed [31:0]   kq;
  logic                 k_done;
  logic signed [SW-1:0] s_w;

  assign dt_m = MW'($signed({1'b0, cfg.time_step}));
  assign qb_m = MW'($signed({1'b0, cfg.q_bias}));
  assign s_w  = SW'(aa_r) + SW'($signed({1'b0, cfg.r_measure}));

  always_comb begin
    case (cmd.op)
      MOP_ANG: begin ma = dt_m;       mb = MW'(rate_r);  end
      MOP_D:   begin ma = dt_m;       mb = MW'(bb_r);    end
      MOP_AA:  begin ma = dt_m;       mb = MW'(inner_r); end
      MOP_BB:  begin ma = qb_m;       mb = dt_m;         end
      MOP_A2:  begin ma = MW'(k0_r);  mb = MW'(y_r);     end
      MOP_B2:  begin ma = MW'(k1_r);  mb = MW'(y_r);     end
      MOP_P0:  begin ma = MW'(k0_r);  mb = MW'(p00_r);   end
      MOP_P1:  begin ma = MW'(k0_r);  mb = MW'(p01_r);   end
      MOP_P2:  begin ma = MW'(k1_r);  mb = MW'(p00_r);   end
      MOP_P3:  begin ma = MW'(k1_r);  mb = MW'(p01_r);   end
      default: begin ma = '0;         mb = '0;           end
    endcase
  end

  tkf_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start),
    .a(ma), .b(mb), .p(m), .done(m_done)
  );

  tkf_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(cmd.div_sel ? ba_r : aa_r), .den(s_r[SW-2:0]),
    .q(kq), .done(k_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      bias_r  <= '0;
      aa_r    <= '0;
      ab_r    <= '0;
      ba_r    <= '0;
      bb_r    <= '0;
    end else if (cmd.mul_wb) begin
      case (cmd.op)
        MOP_ANG: angle_r <= sat(XW'(angle_r) + XW'(m));
        MOP_AA: begin
          aa_r <= sat(XW'(aa_r) + XW'(m));
          ab_r <= sat(XW'(ab_r) - XW'(d_r));
          ba_r <= sat(XW'(ba_r) - XW'(d_r));
        end
        MOP_BB:  bb_r    <= sat(XW'(bb_r) + XW'(m));
        MOP_A2:  angle_r <= sat(XW'(angle_r) + XW'(m));
        MOP_B2:  bias_r  <= sat(XW'(bias_r) + XW'(m));
        MOP_P0:  aa_r    <= sat(XW'(aa_r) - XW'(m));
        MOP_P1:  ab_r    <= sat(XW'(ab_r) - XW'(m));
        MOP_P2:  ba_r    <= sat(XW'(ba_r) - XW'(m));
        MOP_P3:  bb_r    <= sat(XW'(bb_r) - XW'(m));
        default: ;
      endcase
    end
  end

  // temporaries
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r  <= in_accel_angle;
      rate_r <= sat(XW'(in_gyro_rate) - XW'(bias_r));
    end
    if (cmd.mul_wb && (cmd.op == MOP_D)) begin
      d_r     <= m;
      inner_r <= IW'(m) - IW'(ab_r) - IW'(ba_r) + IW'($signed({1'b0, cfg.q_angle}));
    end
    if (cmd.ys) begin
      y_r   <= sat(XW'(acc_r) - XW'(angle_r));
      s_r   <= s_w;
      p00_r <= aa_r;
      p01_r <= ab_r;
      k0_r  <= '0;
      k1_r  <= '0;
    end
    if (cmd.div_wb) begin
      if (cmd.div_sel) k1_r <= kq;
      else             k0_r <= kq;
    end
    if (cmd.out_load) begin
      out_ang_r  <= 32'(angle_r);
      out_bias_r <= 32'(bias_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready)    out_valid_r <= 1'b0;
  end

  assign sts.mul_done = m_done;
  assign sts.div_done = k_done;
  assign sts.s_pos    = !s_w[SW-1] && (s_w != '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_ang_r;
  assign out_bias_estimate  = out_bias_r;
endmodule

// ----- hdl/tkf_ctrl.sv -----
// Sequencer for one filter update: ten multiplies, two gain divides
// if S > 0. Issues tkf_pkg::cmd_t to the datapath, reads its status.
module tkf_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  tkf_pkg::sts_t sts,
  output tkf_pkg::cmd_t cmd
);
  import tkf_pkg::*;

  state_t state_r, state_nxt;
  mop_t   op_r, op_nxt;
  logic   ksel_r, ksel_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ksel_nxt  = ksel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL_GO;
          op_nxt    = MOP_ANG;
        end
      end
      ST_MUL_GO:   state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (sts.mul_done) begin
          if (op_r == MOP_BB)      state_nxt = ST_YS;
          else if (op_r == MOP_P3) state_nxt = ST_DONE;
          else begin
            state_nxt = ST_MUL_GO;
            op_nxt    = mop_t'(op_r + 4'd1);
          end
        end
      end
      ST_YS: begin
        // non-positive variance: gains stay zero
        if (sts.s_pos) begin
          state_nxt = ST_DIV_GO;
          ksel_nxt  = 1'b0;
        end else begin
          state_nxt = ST_MUL_GO;
          op_nxt    = MOP_A2;
        end
      end
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          if (!ksel_r) begin
            state_nxt = ST_DIV_GO;
            ksel_nxt  = 1'b1;
          end else begin
            state_nxt = ST_MUL_GO;
            op_nxt    = MOP_A2;
          end
        end
      end
      ST_DONE: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = op_r;
    cmd.div_sel   = ksel_r;
    cmd.load      = (state_r == ST_IDLE) && in_valid;
    cmd.mul_start = (state_r == ST_MUL_GO);
    cmd.mul_wb    = (state_r == ST_MUL_WAIT) && sts.mul_done;
    cmd.ys        = (state_r == ST_YS);
    cmd.div_start = (state_r == ST_DIV_GO);
    cmd.div_wb    = (state_r == ST_DIV_WAIT) && sts.div_done;
    cmd.out_load  = (state_r == ST_DONE) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= MOP_ANG;
      ksel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ksel_r  <= ksel_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
endmodule

// ----- hdl/tilt_kalman_filter.sv -----
// Top level of the two-state tilt Kalman filter (angle and gyro bias).
// Depends on tkf_pkg, tkf_ctrl, tkf_datapath (with tkf_mul and tkf_div).
//
// Input channel in_valid/in_ready: one request carries an accelerometer
// angle and a gyro rate (signed Q8.24). Result channel out_valid/out_ready:
// one request per input with the updated angle and bias estimate.
// Configuration channel cfg_valid/cfg_ready (always ready): cfg_index
// selects q_angle, q_bias, r_measure or time_step; other indexes are dropped.
// Write configuration only while the filter is idle.
// An update runs ten multiplies on the shared multiplier and two gain
// divides on the one-bit-a-cycle divider, with innovation and variance in
// ST_YS and the result load in ST_DONE; when the innovation variance is
// not positive the divides are skipped. One request is in work at a time;
// in_ready is high only while the sequencer is idle, so a new request is
// taken only once the last update has loaded its result.
// The result sits in an output register: the next input is taken while it
// waits, but that update cannot finish until the receiver takes the result.
// Reset (synchronous, rst_n low) zeroes the state and covariance and loads
// default noise settings and a 2 ms time step.
module tilt_kalman_filter #(
  parameter int DATA_WIDTH = tkf_pkg::DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] in_accel_angle,
  input  logic signed [31:0] in_gyro_rate,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] out_filtered_angle,
  output logic signed [31:0] out_bias_estimate,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [tkf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tkf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tkf_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.q_angle   <= Q_ANGLE_RST;
      cfg_r.q_bias    <= Q_BIAS_RST;
      cfg_r.r_measure <= R_MEASURE_RST;
      cfg_r.time_step <= TIME_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_W'(REG_Q_ANGLE):   cfg_r.q_angle   <= cfg_data[23:0];
        CFG_IDX_W'(REG_Q_BIAS):    cfg_r.q_bias    <= cfg_data[23:0];
        CFG_IDX_W'(REG_R_MEASURE): cfg_r.r_measure <= cfg_data;
        CFG_IDX_W'(REG_TIME_STEP): cfg_r.time_step <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  tkf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  tkf_datapath #(.W(DATA_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg(cfg_r), .cmd(cmd), .sts(sts),
    .in_accel_angle(in_accel_angle), .in_gyro_rate(in_gyro_rate),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_filtered_angle(out_filtered_angle),
    .out_bias_estimate(out_bias_estimate)
  );

  // an accepted request leaves the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a fresh result only follows the end of an update
  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised while idle");

endmodule

// ----- dv/tilt_kalman_filter_tb.sv -----
// Self-checking testbench for tilt_kalman_filter: directed table, then random traffic.
// Depends on tkf_pkg and the block's RTL; carries its own fixed-point filter model.
`timescale 1ns / 100ps

module tilt_kalman_filter_tb;
  import tkf_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_SPARE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST_SPARE  = 4'd15;
  localparam int N_DIRECTED = 20;
  localparam int N_ZERO_VAR = 8;   // leading table rows run with zero variance
  localparam int N_PER_MODE = 85;
  localparam int N_CFG_SETS = 6;

  typedef enum int { IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH } idle_mode_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  typedef struct {
    logic signed [31:0] accel;
    logic signed [31:0] gyro;
    bit                 typed;   // expected result given in the row
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_accel_angle = '0;
  logic signed [31:0] in_gyro_rate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_filtered_angle;
  logic signed [31:0] out_bias_estimate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tilt_kalman_filter i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state and configuration shadow
  logic [23:0] m_q_angle, m_q_bias, m_time_step;
  logic [27:0] m_r_measure;
  longint est_angle, est_bias, cov_aa, cov_ab, cov_ba, cov_bb;

  estimate_t result_q[$];
  stim_row_t row_q[$];       // one per request offered, in order
  int        fail_cnt = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  int        hold_start = 0;

  function automatic longint sat32(longint x);
    if (x > SAT_HI) return SAT_HI;
    if (x < SAT_LO) return SAT_LO;
    return x;
  endfunction

  // Q8.24 product, rounded half away from zero, saturated
  function automatic longint qmul(longint a, longint b);
    bit neg;
    logic [127:0] p, m;
    logic [127:0] maxmag;
    neg = (a < 0) != (b < 0);
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    m = (p >> FRAC_BITS) + p[FRAC_BITS-1];
    maxmag = neg ? 128'd2147483648 : 128'd2147483647;
    if (m > maxmag) m = maxmag;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  // num/den in Q8.24, den > 0, truncated; saturates at magnitude 128
  function automatic longint qgain(longint num, longint den);
    bit neg;
    logic [127:0] un, q;
    neg = num < 0;
    un = 128'(neg ? -num : num);
    if (un / 128'(den) >= 128) return neg ? SAT_LO : SAT_HI;
    q = (un << FRAC_BITS) / 128'(den);
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic estimate_t kalman_update(logic signed [31:0] accel,
                                              logic signed [31:0] gyro);
    longint dt, rate, d, inner, y, s, k0, k1, p00, p01;
    estimate_t r;
    dt = longint'(m_time_step);
    // predict
    rate = sat32(longint'(gyro) - est_bias);
    est_angle = sat32(est_angle + qmul(dt, rate));
    d = qmul(dt, cov_bb);
    inner = d - cov_ab - cov_ba + longint'(m_q_angle);
    cov_aa = sat32(cov_aa + qmul(dt, inner));
    cov_ab = sat32(cov_ab - d);
    cov_ba = sat32(cov_ba - d);
    cov_bb = sat32(cov_bb + qmul(longint'(m_q_bias), dt));
    // correct; no gain when the variance is not positive
    y = sat32(longint'(accel) - est_angle);
    s = cov_aa + longint'(m_r_measure);
    k0 = 0;
    k1 = 0;
    if (s > 0) begin
      k0 = qgain(cov_aa, s);
      k1 = qgain(cov_ba, s);
    end
    est_angle = sat32(est_angle + qmul(k0, y));
    est_bias = sat32(est_bias + qmul(k1, y));
    p00 = cov_aa;
    p01 = cov_ab;
    cov_aa = sat32(cov_aa - qmul(k0, p00));
    cov_ab = sat32(cov_ab - qmul(k0, p01));
    cov_ba = sat32(cov_ba - qmul(k1, p00));
    cov_bb = sat32(cov_bb - qmul(k1, p01));
    r.angle = est_angle[31:0];
    r.bias = est_bias[31:0];
    return r;
  endfunction

  initial begin
    m_q_angle = Q_ANGLE_RST;
    m_q_bias = Q_BIAS_RST;
    m_r_measure = R_MEASURE_RST;
    m_time_step = TIME_STEP_RST;
    {est_angle, est_bias, cov_aa, cov_ab, cov_ba, cov_bb} = '0;
  end

  // ---------------------------------------------------------------------------
  // Monitors: all sample on the rising edge, so they see pre-edge values
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_W'(REG_Q_ANGLE):   m_q_angle   = cfg_data[23:0];
        CFG_IDX_W'(REG_Q_BIAS):    m_q_bias    = cfg_data[23:0];
        CFG_IDX_W'(REG_R_MEASURE): m_r_measure = cfg_data[27:0];
        CFG_IDX_W'(REG_TIME_STEP): m_time_step = cfg_data[23:0];
        default: ;   // spare index, dropped by the block
      endcase
    end
  end

  // accepted request: advance the model, queue the expected result
  always @(posedge clk) begin
    estimate_t e;
    stim_row_t row;
    if (rst_n && in_valid && in_ready) begin
      row = row_q.pop_front();
      e = kalman_update(in_accel_angle, in_gyro_rate);
      if (row.typed) begin
        e.angle = row.angle;
        e.bias = row.bias;
      end
      result_q.push_back(e);
    end
  end

  always @(posedge clk) begin
    estimate_t e;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $error("result with nothing expected: angle %0d bias %0d",
               out_filtered_angle, out_bias_estimate);
        fail_cnt++;
      end else begin
        e = result_q.pop_front();
        if (out_filtered_angle !== e.angle) begin
          $error("filtered_angle: expected %0d, got %0d", e.angle, out_filtered_angle);
          fail_cnt++;
        end
        if (out_bias_estimate !== e.bias) begin
          $error("bias_estimate: expected %0d, got %0d", e.bias, out_bias_estimate);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int hold_left;
    if (hold_start > 0) begin
      hold_left = hold_start;
      hold_start = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // valid stays up between back-to-back requests; lowered only for a gap
  task automatic send_req(stim_row_t row);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    row_q.push_back(row);
    in_valid <= 1'b1;
    in_accel_angle <= row.accel;
    in_gyro_rate <= row.gyro;
    do @(posedge clk); while (!in_ready);
  endtask

  // valid stays up across back-to-back writes; write_all lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_all(logic [23:0] qa, logic [23:0] qb, logic [27:0] rm,
                           logic [23:0] ts);
    write_reg(CFG_IDX_W'(REG_Q_ANGLE), CFG_DATA_W'(qa));
    write_reg(CFG_IDX_W'(REG_Q_BIAS), CFG_DATA_W'(qb));
    write_reg(CFG_IDX_W'(REG_R_MEASURE), rm);
    write_reg(CFG_IDX_W'(REG_TIME_STEP), CFG_DATA_W'(ts));
    // spare index: must leave everything alone
    write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_LAST_SPARE, CFG_IDX_FIRST_SPARE)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // settle before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(19))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return $urandom;
      default: return $signed($urandom_range(180 * 65536)) - 90 * 65536;
    endcase
  endfunction

  stim_row_t directed[N_DIRECTED] = '{
    // zero variance (dt = 0, r = 0): nothing moves, every result reads zero
    '{32'sh7fffffff, 32'sh7fffffff, 1'b1, 32'sd0, 32'sd0},
    '{32'sh80000000, 32'sh80000000, 1'b1, 32'sd0, 32'sd0},
    '{32'sh7fffffff, 32'sh80000000, 1'b1, 32'sd0, 32'sd0},
    '{32'sh80000000, 32'sh7fffffff, 1'b1, 32'sd0, 32'sd0},
    '{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0},
    '{-32'sd1, 32'sd1, 1'b1, 32'sd0, 32'sd0},
    '{32'sh55555555, 32'shaaaaaaaa, 1'b1, 32'sd0, 32'sd0},
    '{32'shaaaaaaaa, 32'sh55555555, 1'b1, 32'sd0, 32'sd0},
    // default tuning, still from zero state: a zero sample reads zero
    '{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0},
    '{32'sd655360, 32'sd0, 1'b0, 32'sd0, 32'sd0},
    '{32'sd655360, 32'sd65536, 1'b0, 32'sd0, 32'sd0},
    '{-32'sd655360, -32'sd65536, 1'b0, 32'sd0, 32'sd0},
    '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0},
    '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0},
    '{32'sh80000000, 32'sh80000000, 1'b0, 32'sd0, 32'sd0},
    '{32'sh80000000, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0},
    '{32'sd1, -32'sd1, 1'b0, 32'sd0, 32'sd0},
    '{32'sh55555555, 32'shaaaaaaaa, 1'b0, 32'sd0, 32'sd0},
    '{32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0},
    '{32'sd2949120, 32'sd0, 1'b0, 32'sd0, 32'sd0}
  };

  initial begin
    stim_row_t row;
    logic [23:0] qa, qb, ts;
    logic [27:0] rm;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed table
    write_all(Q_ANGLE_RST, Q_BIAS_RST, 28'd0, 24'd0);
    foreach (directed[i]) begin
      if (i == N_ZERO_VAR) begin
        drain();
        write_all(Q_ANGLE_RST, Q_BIAS_RST, R_MEASURE_RST, TIME_STEP_RST);
      end
      send_req(directed[i]);
    end
    drain();

    // random part: several tunings, each through every idling mode
    for (int set = 0; set < N_CFG_SETS; set++) begin
      case (set)
        0: {qa, qb, rm, ts} = {Q_ANGLE_RST, Q_BIAS_RST, R_MEASURE_RST, TIME_STEP_RST};
        1: {qa, qb, rm, ts} = {24'hffffff, 24'hffffff, 28'hfffffff, 24'hffffff};
        2: {qa, qb, rm, ts} = '0;
        3: {qa, qb, rm, ts} = {24'd1, 24'd1, 28'd1, 24'hffffff};
        default: begin
          qa = 24'($urandom);
          qb = 24'($urandom);
          rm = 28'($urandom);
          ts = 24'($urandom_range(1 << 20));
        end
      endcase
      write_all(qa, qb, rm, ts);
      for (int mode = IDLE_NONE; mode <= IDLE_BOTH; mode++) begin
        case (idle_mode_t'(mode))
          IDLE_NONE: {src_idle_pct, snk_idle_pct} = {32'd0, 32'd0};
          IDLE_SRC:  {src_idle_pct, snk_idle_pct} = {32'd45, 32'd0};
          IDLE_SNK:  {src_idle_pct, snk_idle_pct} = {32'd0, 32'd45};
          IDLE_BOTH: {src_idle_pct, snk_idle_pct} = {32'd32, 32'd32};
          default:   {src_idle_pct, snk_idle_pct} = {32'd0, 32'd0};
        endcase
        for (int n = 0; n < N_PER_MODE; n++) begin
          // long receiver hold-off: the block backs up onto its input
          if (set == 0 && mode == IDLE_NONE && n == 5) hold_start = 600;
          row.accel = rand_value();
          row.gyro = rand_value();
          row.typed = 1'b0;
          row.angle = '0;
          row.bias = '0;
          send_req(row);
        end
        src_idle_pct = 0;
      end
      drain();
    end

    snk_idle_pct = 0;
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

endmodule
